@@ hdl/utf8_stream_validator_assert.svh @@
// Assertion macros shared by the utf8_stream_validator RTL.
`ifndef UTF8_STREAM_VALIDATOR_ASSERT_SVH
`define UTF8_STREAM_VALIDATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define U8SV_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8sv assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define U8SV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8sv assertion failed");

`endif

@@ hdl/u8sv_pkg.sv @@
// Types and constants shared by the utf8_stream_validator modules.
`default_nettype none

package u8sv_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] BYTE_SPACE    = 8'h20;
    localparam logic [7:0] BYTE_DEL      = 8'h7F;
    localparam logic [7:0] BYTE_CONT_LO  = 8'h80;
    localparam logic [7:0] BYTE_CONT_HI  = 8'hBF;
    localparam logic [7:0] BYTE_LEAD2_LO = 8'hC2;
    localparam logic [7:0] BYTE_LEAD2_HI = 8'hDF;
    localparam logic [7:0] BYTE_LEAD3_LO = 8'hE0;
    localparam logic [7:0] BYTE_LEAD3_HI = 8'hEF;
    localparam logic [7:0] BYTE_LEAD4_LO = 8'hF0;
    localparam logic [7:0] BYTE_LEAD4_HI = 8'hF4;

    localparam int CODE_W = 21;
    localparam logic [CODE_W-1:0] CODE_MIN2    = 21'h000080;
    localparam logic [CODE_W-1:0] CODE_MIN3    = 21'h000800;
    localparam logic [CODE_W-1:0] CODE_MIN4    = 21'h010000;
    localparam logic [CODE_W-1:0] CODE_MAX     = 21'h10FFFF;
    localparam logic [CODE_W-1:0] CODE_SURR_LO = 21'h00D800;
    localparam logic [CODE_W-1:0] CODE_SURR_HI = 21'h00DFFF;
    localparam logic [CODE_W-1:0] CODE_C1_LO   = 21'h000080;
    localparam logic [CODE_W-1:0] CODE_C1_HI   = 21'h00009F;

    typedef enum logic [2:0] {
        CLS_PRINT = 3'd0,
        CLS_CTRL  = 3'd1,
        CLS_LEAD2 = 3'd2,
        CLS_LEAD3 = 3'd3,
        CLS_LEAD4 = 3'd4,
        CLS_CONT  = 3'd5,
        CLS_BAD   = 3'd6
    } byte_cls_t;

    typedef enum logic [1:0] {
        LC_NONE  = 2'd0,
        LC_TWO   = 2'd1,
        LC_THREE = 2'd2,
        LC_FOUR  = 2'd3
    } lead_cls_t;

    typedef struct packed {
        byte_cls_t  cls;
        logic [5:0] bits;
        logic       last;
    } item_t;

endpackage

`default_nettype wire

@@ hdl/u8sv_front.sv @@
// Front stage: accept bytes and classify them into queue items.
`default_nettype none

module u8sv_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            data_valid,
    output logic                 data_stall,
    input  wire logic [7:0]      data_byte,
    input  wire logic            last,
    output logic                 push,
    output u8sv_pkg::item_t      push_item,
    input  wire logic            q_full
);

    logic              hold_valid_reg;
    logic              hold_valid_next;
    u8sv_pkg::item_t   hold_item_reg;
    u8sv_pkg::byte_cls_t cls;
    logic              accept;

    always_comb
    begin
        case (data_byte) inside
            [u8sv_pkg::BYTE_SPACE : u8sv_pkg::BYTE_DEL - 8'd1]:
                cls = u8sv_pkg::CLS_PRINT;
            [8'h00 : u8sv_pkg::BYTE_SPACE - 8'd1], u8sv_pkg::BYTE_DEL:
                cls = u8sv_pkg::CLS_CTRL;
            [u8sv_pkg::BYTE_CONT_LO : u8sv_pkg::BYTE_CONT_HI]:
                cls = u8sv_pkg::CLS_CONT;
            [u8sv_pkg::BYTE_LEAD2_LO : u8sv_pkg::BYTE_LEAD2_HI]:
                cls = u8sv_pkg::CLS_LEAD2;
            [u8sv_pkg::BYTE_LEAD3_LO : u8sv_pkg::BYTE_LEAD3_HI]:
                cls = u8sv_pkg::CLS_LEAD3;
            [u8sv_pkg::BYTE_LEAD4_LO : u8sv_pkg::BYTE_LEAD4_HI]:
                cls = u8sv_pkg::CLS_LEAD4;
            default:
                cls = u8sv_pkg::CLS_BAD;
        endcase
    end

    assign data_stall = hold_valid_reg && q_full;
    assign accept     = data_valid && !data_stall;
    assign push       = hold_valid_reg && !q_full;
    assign push_item  = hold_item_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_item_reg.cls  <= cls;
            hold_item_reg.bits <= data_byte[5:0];
            hold_item_reg.last <= last;
        end
    end

endmodule

`default_nettype wire

@@ hdl/u8sv_queue.sv @@
// Short queue of classified items between front and back stages.
`default_nettype none

module u8sv_queue #(
    parameter int DEPTH = u8sv_pkg::QUEUE_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire u8sv_pkg::item_t push_item,
    output logic                 full,
    input  wire logic            pop,
    output logic                 q_valid,
    output u8sv_pkg::item_t      pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    u8sv_pkg::item_t   slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full     = (count_reg == CNT_FULL);
    assign q_valid  = (count_reg != '0);
    assign pop_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

`include "utf8_stream_validator_assert.svh"

    `U8SV_ASSERT_NOW(a_no_push_when_full, full, !push)
    `U8SV_ASSERT_NOW(a_no_pop_when_empty, pop, q_valid)
    `U8SV_ASSERT_NEXT(a_pop_drains, pop && !push, count_reg == $past(count_reg) - CNT_W'(1))

endmodule

`default_nettype wire

@@ hdl/u8sv_back.sv @@
// Back stage: run the decoder state and deliver one result per string.
`default_nettype none

module u8sv_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    input  wire u8sv_pkg::item_t pop_item,
    output logic                 pop,
    output logic                 res_valid,
    input  wire logic            res_stall,
    output logic                 valid_res
);

    logic [1:0]                  pending_reg;
    logic [1:0]                  pending_next;
    logic [u8sv_pkg::CODE_W-1:0] partial_reg;
    logic [u8sv_pkg::CODE_W-1:0] partial_next;
    u8sv_pkg::lead_cls_t         lead_reg;
    u8sv_pkg::lead_cls_t         lead_next;
    logic                        err_reg;
    logic                        err_next;
    logic                        res_valid_reg;
    logic                        res_valid_next;
    logic                        valid_res_reg;
    logic                        valid_res_next;
    logic [u8sv_pkg::CODE_W-1:0] code_shift;

    function automatic logic code_ok(
        input logic [u8sv_pkg::CODE_W-1:0] code,
        input u8sv_pkg::lead_cls_t lc
    );
        logic [u8sv_pkg::CODE_W-1:0] minimum;
        case (lc)
            u8sv_pkg::LC_TWO:   minimum = u8sv_pkg::CODE_MIN2;
            u8sv_pkg::LC_THREE: minimum = u8sv_pkg::CODE_MIN3;
            default:            minimum = u8sv_pkg::CODE_MIN4;
        endcase
        code_ok = (code >= minimum)
            && (code <= u8sv_pkg::CODE_MAX)
            && !((code >= u8sv_pkg::CODE_SURR_LO) && (code <= u8sv_pkg::CODE_SURR_HI))
            && !((code >= u8sv_pkg::CODE_C1_LO) && (code <= u8sv_pkg::CODE_C1_HI));
    endfunction

    assign pop        = q_valid && (!pop_item.last || !res_valid_reg || !res_stall);
    assign res_valid  = res_valid_reg;
    assign valid_res  = valid_res_reg;
    assign code_shift = {partial_reg[u8sv_pkg::CODE_W-7:0], pop_item.bits};

    always_comb
    begin
        pending_next   = pending_reg;
        partial_next   = partial_reg;
        lead_next      = lead_reg;
        err_next       = err_reg;
        res_valid_next = res_valid_reg;
        valid_res_next = valid_res_reg;
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
        if (pop)
        begin
            if (pending_reg == 2'd0)
            begin
                case (pop_item.cls)
                    u8sv_pkg::CLS_PRINT:
                    begin
                    end
                    u8sv_pkg::CLS_LEAD2:
                    begin
                        pending_next = 2'd1;
                        partial_next = {16'd0, pop_item.bits[4:0]};
                        lead_next    = u8sv_pkg::LC_TWO;
                    end
                    u8sv_pkg::CLS_LEAD3:
                    begin
                        pending_next = 2'd2;
                        partial_next = {17'd0, pop_item.bits[3:0]};
                        lead_next    = u8sv_pkg::LC_THREE;
                    end
                    u8sv_pkg::CLS_LEAD4:
                    begin
                        pending_next = 2'd3;
                        partial_next = {18'd0, pop_item.bits[2:0]};
                        lead_next    = u8sv_pkg::LC_FOUR;
                    end
                    default:
                    begin
                        err_next = 1'b1;
                    end
                endcase
            end
            else
            begin
                if (pop_item.cls != u8sv_pkg::CLS_CONT)
                begin
                    err_next = 1'b1;
                end
                partial_next = code_shift;
                pending_next = pending_reg - 2'd1;
                if (pending_reg == 2'd1)
                begin
                    if (!code_ok(code_shift, lead_reg))
                    begin
                        err_next = 1'b1;
                    end
                    partial_next = '0;
                    lead_next    = u8sv_pkg::LC_NONE;
                end
            end
            if (pop_item.last)
            begin
                res_valid_next = 1'b1;
                valid_res_next = !(err_next || (pending_next != 2'd0));
                pending_next   = 2'd0;
                partial_next   = '0;
                lead_next      = u8sv_pkg::LC_NONE;
                err_next       = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 2'd0;
            partial_reg   <= '0;
            lead_reg      <= u8sv_pkg::LC_NONE;
            err_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg   <= pending_next;
            partial_reg   <= partial_next;
            lead_reg      <= lead_next;
            err_reg       <= err_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        valid_res_reg <= valid_res_next;
    end

`include "utf8_stream_validator_assert.svh"

    `U8SV_ASSERT_NOW(a_pending_has_lead, pending_reg != 2'd0, lead_reg != u8sv_pkg::LC_NONE)
    `U8SV_ASSERT_NOW(a_idle_code_clear, pending_reg == 2'd0, partial_reg == '0)
    `U8SV_ASSERT_NEXT(a_last_clears, pop && pop_item.last, pending_reg == 2'd0 && !err_reg)

endmodule

`default_nettype wire

@@ hdl/utf8_stream_validator.sv @@
// Top level of the restricted UTF-8 stream validator.
// Input channel: data_valid/data_stall carry one byte (data_byte) per transaction;
// last marks the final byte of a string. Every byte is one transaction.
// Output channel: res_valid/res_stall carry one result (valid_res) per string,
// 1 when the whole string is valid restricted UTF-8.
// Throughput: one byte per cycle when not stalled, set by the decoder update in the
// back stage. The front stage registers and classifies each byte, a queue of
// QUEUE_DEPTH entries decouples it from the back stage, and the back stage
// updates the decoder and loads the output register.
// Result path: a final byte passes the front hold register and a queue slot before
// the back stage registers res_valid and valid_res.
// While res_stall holds the result, bytes that are not final keep flowing;
// the next final byte waits in the queue, then the queue and front back up
// and data_stall rises.
// Reset (rst_n low, asynchronous) empties the queue, drops a held byte and any
// undelivered result, and clears the decoder state.
`default_nettype none

module utf8_stream_validator #(
    parameter int QUEUE_DEPTH = u8sv_pkg::QUEUE_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       data_valid,
    output logic            data_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       last,
    output logic            res_valid,
    input  wire logic       res_stall,
    output logic            valid_res
);

    logic              push;
    u8sv_pkg::item_t   push_item;
    logic              q_full;
    logic              pop;
    logic              q_valid;
    u8sv_pkg::item_t   pop_item;

    u8sv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_stall (data_stall),
        .data_byte  (data_byte),
        .last       (last),
        .push       (push),
        .push_item  (push_item),
        .q_full     (q_full)
    );

    u8sv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .pop_item  (pop_item)
    );

    u8sv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .pop_item  (pop_item),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .valid_res (valid_res)
    );

endmodule

`default_nettype wire
